FILE: rtl/core/srpg_pkg.sv
// Shared types, constants and command codes for the stepper ramp pulse generator.
// Used by the front, back and top modules in rtl/core; depends on nothing.
package srpg_pkg;
   localparam int TicksPerSecond = 1000000;
   localparam int PositionWidth  = 24;
   localparam int SpeedWidth     = 16;
   localparam int CountWidth     = 19;
   localparam int FuncWidth      = 3;
   localparam int StepsWidth     = 25;
   localparam int QueueDepth     = 2;

   typedef enum logic [2:0] {
      FUNC_TICK  = 3'd0,
      FUNC_MOVE  = 3'd1,
      FUNC_START = 3'd2,
      FUNC_STOP  = 3'd3,
      FUNC_HOME  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_RUN     = 2'd0,
      ST_IDLE    = 2'd1,
      ST_SWITCH  = 2'd2,
      ST_REFUSED = 2'd3
   } status_type;

   localparam logic [2:0] CSR_ACCEL   = 3'd0;
   localparam logic [2:0] CSR_MAXSPD  = 3'd1;
   localparam logic [2:0] CSR_MINSPD  = 3'd2;
   localparam logic [2:0] CSR_MAXPOS  = 3'd3;
   localparam logic [2:0] CSR_SPMM    = 3'd4;
   localparam logic [2:0] CSR_MMMODE  = 3'd5;
   localparam logic [2:0] CSR_ENDSW   = 3'd6;
   localparam logic [2:0] CSR_ENLEVEL = 3'd7;

   // One classified command as it travels from the front to the back.
   typedef struct packed {
      logic                  valid_cmd;
      logic [2:0]            func;
      logic                  neg;
      logic [PositionWidth:0] mag;
      logic [15:0]           speed;
      logic                  sw;
   } cmd_type;
endpackage

FILE: rtl/core/srpg_divider.sv
// Restoring divider, one quotient bit per cycle, for half periods and speed scaling.
// Does not depend on srpg_pkg; widths are parameters.
module srpg_divider #(
   parameter int Width = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [Width-1:0] dividend,
   input  logic [Width-1:0] divisor,
   output logic             done,
   output logic [Width-1:0] quotient
);
   localparam int CntW = $clog2(Width + 1);
   logic [Width-1:0] quot_ff, quot_in;
   logic [Width-1:0] rem_ff, rem_in;
   logic [Width-1:0] dvs_ff, dvs_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [Width:0]   trial;

   // One shift-subtract step per cycle.
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quot_ff[Width-1]} - {1'b0, dvs_ff};
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CntW'(Width);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[Width]) begin
            rem_in  = trial[Width-1:0];
            quot_in = {quot_ff[Width-2:0], 1'b1};
         end else begin
            rem_in  = {rem_ff[Width-2:0], quot_ff[Width-1]};
            quot_in = {quot_ff[Width-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;
endmodule

FILE: rtl/core/srpg_front.sv
// Front end: accepts request transactions, decodes the command and queues it.
// Depends on srpg_pkg.
module srpg_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [47:0]                req_tdata,
   output srpg_pkg::cmd_type          cmd,
   input  logic                       cmd_pop
);
   localparam int Depth = srpg_pkg::QueueDepth;
   srpg_pkg::cmd_type q_ff [Depth];
   logic [0:0] wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   srpg_pkg::cmd_type dec;
   logic [24:0] raw;
   logic        push;

   // Decode: function code, sign and magnitude of the step count, speed and end switch.
   always_comb begin
      raw           = req_tdata[27:3];
      dec.valid_cmd = 1'b1;
      dec.func      = req_tdata[2:0];
      dec.neg       = raw[24];
      // Only the most negative count yields a magnitude with the top bit set.
      dec.mag       = raw[24] ? (25'd0 - raw) : raw;
      dec.speed     = req_tdata[43:28];
      dec.sw        = req_tdata[44];
   end

   assign req_tready = cnt_ff != 2'(Depth);
   assign push       = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (cmd_pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + 2'(push) - 2'(cmd_pop);
      end
      if (push) q_ff[wr_ff] <= dec;
   end

   always_comb begin
      cmd           = q_ff[rd_ff];
      cmd.valid_cmd = cnt_ff != '0;
   end

   property p_no_overflow;
      @(posedge clock) disable iff (reset) cnt_ff <= 2'(Depth);
   endproperty
   a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cnt_ff != '0) else $error("pop from empty queue");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'(Depth) |-> !req_tready) else $error("ready while full");
endmodule

FILE: rtl/core/srpg_back.sv
// Back end: motion state, ramp and step pulse sequencing using a shared divider.
// Depends on srpg_pkg and srpg_divider.
module srpg_back #(
   parameter int TicksPerSecond = srpg_pkg::TicksPerSecond
) (
   input  logic                     clock,
   input  logic                     reset,
   input  srpg_pkg::cmd_type        cmd,
   output logic                     cmd_pop,
   input  logic                     csr_we,
   input  logic [2:0]               csr_index,
   input  logic [23:0]              csr_wdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [71:0]              rsp_tdata
);
   localparam int PositionWidth = srpg_pkg::PositionWidth;
   localparam int DW = 32;
   localparam logic [DW-1:0] HalfTicks = DW'(TicksPerSecond / 2);
   localparam logic [18:0]   CountMax  = 19'h7FFFF;
   localparam logic [23:0]   RemMax    = 24'hFFFFFF;

   typedef enum logic [2:0] {
      S_IDLE, S_DIV_MM, S_WAIT_MM, S_DIV_HP, S_WAIT_HP, S_OUT
   } state_type;

   state_type state_ff;
   // configuration
   logic [15:0] accel_ff, maxspd_ff, minspd_ff, spmm_ff;
   logic [23:0] maxpos_ff;
   logic        mm_ff, endsw_ff, enlevel_ff;
   // motion state
   logic [PositionWidth-1:0] pos_ff;
   logic [23:0] rem_ff;
   logic [15:0] rspd_ff, tspd_ff;
   logic [18:0] cd_ff;
   logic        neg_ff, homing_ff, phase_ff, run_ff, pin_ff;
   // working
   logic [1:0]  status_ff;
   logic        hp_next_ff;   // after half period: 1 = ramp+toggle tick, 0 = start
   logic        out_full_ff;
   logic [71:0] out_ff;
   logic [23:0] mv_rem_ff;
   logic        mv_neg_ff;
   logic [15:0] mv_spd_ff;    // commanded speed of the move or home being loaded
   logic [15:0] spd_nx_ff;    // ramp speed that takes effect once the half period is known

   logic        div_start, div_done;
   logic [DW-1:0] div_a, div_b, div_q;
   logic [15:0] acc;

   srpg_divider #(.Width(DW)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_a), .divisor(div_b), .done(div_done), .quotient(div_q)
   );

   assign acc = (accel_ff == '0) ? 16'd1 : accel_ff;

   // Ramp step: spd/acc compared by multiplication, left < spd/acc <=> (left+1)*acc <= spd.
   function automatic logic [15:0] ramp_f(input logic [15:0] spd_i, input logic [23:0] left,
                                          input logic [15:0] a, input logic [15:0] mn,
                                          input logic [15:0] tg);
      logic [16:0] s;
      logic [40:0] prod;
      s    = (spd_i == '0) ? {1'b0, mn} : {1'b0, spd_i};
      prod = 41'(({1'b0, left} + 25'd1)) * 41'(a);
      if (prod <= 41'(s)) s = (s > 17'(a)) ? s - 17'(a) : 17'd0;
      else if (s < 17'(tg)) s = s + 17'(a);
      if (s < 17'(mn)) s = 17'(mn);
      if (s > 17'hFFFF) s = 17'hFFFF;
      return s[15:0];
   endfunction

   logic at_limit;
   assign at_limit = rem_ff == '0 || (pos_ff == '0 && neg_ff) ||
                     (24'(pos_ff) == maxpos_ff && !neg_ff);

   logic [15:0] ramp_next;
   assign ramp_next = ramp_f(rspd_ff, rem_ff, acc, minspd_ff, tspd_ff);

   // The half period is taken from the ramp speed before this tick's ramp step.
   always_comb begin
      div_start = 1'b0;
      div_a     = HalfTicks;
      div_b     = (rspd_ff == '0) ? DW'(1) : DW'(rspd_ff);
      if (state_ff == S_DIV_MM) begin
         div_start = 1'b1;
         div_a     = DW'(mv_spd_ff);
         div_b     = (spmm_ff == '0) ? DW'(1) : DW'(spmm_ff);
      end else if (state_ff == S_DIV_HP) begin
         div_start = 1'b1;
      end
   end

   assign cmd_pop = state_ff == S_IDLE && cmd.valid_cmd && !out_full_ff;

   logic [18:0] hp;
   assign hp = (div_q == '0) ? 19'd1 : (div_q > DW'(CountMax)) ? CountMax : div_q[18:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         accel_ff <= 16'd10; maxspd_ff <= 16'd2000; minspd_ff <= 16'd10;
         maxpos_ff <= 24'hFFFFFF; spmm_ff <= 16'd1;
         mm_ff <= 1'b0; endsw_ff <= 1'b0; enlevel_ff <= 1'b0;
         pos_ff <= '0; rem_ff <= '0; rspd_ff <= '0; tspd_ff <= '0; cd_ff <= '0;
         neg_ff <= 1'b0; homing_ff <= 1'b0; phase_ff <= 1'b0; run_ff <= 1'b0;
         pin_ff <= 1'b0; out_full_ff <= 1'b0; status_ff <= '0; hp_next_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               srpg_pkg::CSR_ACCEL:   accel_ff   <= csr_wdata[15:0];
               srpg_pkg::CSR_MAXSPD:  maxspd_ff  <= csr_wdata[15:0];
               srpg_pkg::CSR_MINSPD:  minspd_ff  <= csr_wdata[15:0];
               srpg_pkg::CSR_MAXPOS:  maxpos_ff  <= csr_wdata;
               srpg_pkg::CSR_SPMM:    spmm_ff    <= csr_wdata[15:0];
               srpg_pkg::CSR_MMMODE:  mm_ff      <= csr_wdata[0];
               srpg_pkg::CSR_ENDSW:   endsw_ff   <= csr_wdata[0];
               srpg_pkg::CSR_ENLEVEL: enlevel_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (out_full_ff && rsp_tready && state_ff != S_OUT) out_full_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (cmd_pop) begin
               unique case (cmd.func)
                  srpg_pkg::FUNC_TICK: begin
                     if (!run_ff) begin
                        status_ff <= srpg_pkg::ST_IDLE; state_ff <= S_OUT;
                     end else if (endsw_ff && neg_ff && !cmd.sw) begin
                        run_ff <= 1'b0; rem_ff <= '0; pos_ff <= '0; homing_ff <= 1'b0;
                        status_ff <= srpg_pkg::ST_SWITCH; state_ff <= S_OUT;
                     end else if (endsw_ff && neg_ff && homing_ff) begin
                        // homing holds position at 1 and remaining at the limit
                        pos_ff <= PositionWidth'(1); rem_ff <= maxpos_ff;
                        if (maxpos_ff == '0) begin
                           run_ff <= 1'b0; status_ff <= srpg_pkg::ST_IDLE; state_ff <= S_OUT;
                        end else if (cd_ff > 19'd1) begin
                           cd_ff <= cd_ff - 1'b1;
                           status_ff <= srpg_pkg::ST_RUN; state_ff <= S_OUT;
                        end else begin
                           spd_nx_ff  <= ramp_f(rspd_ff, maxpos_ff, acc, minspd_ff, tspd_ff);
                           hp_next_ff <= 1'b1;
                           status_ff  <= srpg_pkg::ST_RUN;
                           state_ff   <= S_DIV_HP;
                        end
                     end else if (at_limit) begin
                        run_ff <= 1'b0; rem_ff <= '0;
                        status_ff <= srpg_pkg::ST_IDLE; state_ff <= S_OUT;
                     end else if (cd_ff > 19'd1) begin
                        cd_ff <= cd_ff - 1'b1;
                        status_ff <= srpg_pkg::ST_RUN; state_ff <= S_OUT;
                     end else begin
                        spd_nx_ff  <= ramp_next;
                        hp_next_ff <= 1'b1;
                        status_ff  <= srpg_pkg::ST_RUN;
                        state_ff   <= S_DIV_HP;
                     end
                  end
                  srpg_pkg::FUNC_MOVE, srpg_pkg::FUNC_HOME: begin
                     if (run_ff) begin
                        status_ff <= srpg_pkg::ST_REFUSED; state_ff <= S_OUT;
                     end else begin
                        if (cmd.func == srpg_pkg::FUNC_MOVE) begin
                           mv_neg_ff <= cmd.neg;
                           mv_rem_ff <= cmd.mag[PositionWidth] ? RemMax : 24'(cmd.mag);
                        end else begin
                           mv_neg_ff <= endsw_ff || pos_ff != '0;
                           mv_rem_ff <= endsw_ff ? 24'd1 : 24'(pos_ff);
                           if (endsw_ff) begin
                              pos_ff <= PositionWidth'(1); homing_ff <= 1'b1;
                           end
                        end
                        mv_spd_ff <= cmd.speed;
                        status_ff <= srpg_pkg::ST_RUN;
                        state_ff  <= S_DIV_MM;
                     end
                  end
                  srpg_pkg::FUNC_START: begin
                     if (at_limit) begin
                        status_ff <= srpg_pkg::ST_IDLE; state_ff <= S_OUT;
                     end else begin
                        run_ff <= 1'b1; hp_next_ff <= 1'b0;
                        status_ff <= srpg_pkg::ST_RUN; state_ff <= S_DIV_HP;
                     end
                  end
                  srpg_pkg::FUNC_STOP: begin
                     run_ff <= 1'b0; rem_ff <= '0;
                     status_ff <= srpg_pkg::ST_IDLE; state_ff <= S_OUT;
                  end
                  default: begin
                     status_ff <= srpg_pkg::ST_REFUSED; state_ff <= S_OUT;
                  end
               endcase
            end
            S_DIV_MM: state_ff <= S_WAIT_MM;
            S_WAIT_MM: if (div_done) begin
               logic [15:0] sp;
               sp = mm_ff ? div_q[15:0] : mv_spd_ff;
               neg_ff  <= mv_neg_ff;
               rem_ff  <= mv_rem_ff;
               tspd_ff <= (sp < maxspd_ff) ? sp : maxspd_ff;
               rspd_ff <= ramp_f(16'd0, mv_rem_ff, acc, minspd_ff,
                                 (sp < maxspd_ff) ? sp : maxspd_ff);
               state_ff <= S_OUT;
            end
            S_DIV_HP: state_ff <= S_WAIT_HP;
            S_WAIT_HP: if (div_done) begin
               cd_ff <= hp;
               if (hp_next_ff) begin
                  rspd_ff <= spd_nx_ff;
                  if (phase_ff) begin
                     pin_ff <= 1'b1; phase_ff <= 1'b0;
                  end else begin
                     pin_ff <= 1'b0; phase_ff <= 1'b1;
                     pos_ff <= neg_ff ? pos_ff - 1'b1 : pos_ff + 1'b1;
                     rem_ff <= rem_ff - 1'b1;
                  end
               end
               state_ff <= S_OUT;
            end
            S_OUT: if (!out_full_ff || rsp_tready) begin
               out_full_ff <= 1'b1;
               out_ff <= {3'd0, status_ff, rspd_ff, rem_ff, 24'(pos_ff),
                          run_ff ? enlevel_ff : !enlevel_ff, neg_ff, pin_ff};
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = out_full_ff;
   assign rsp_tdata  = out_ff;

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> state_ff != S_IDLE) else $error("pop did not leave idle");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_full_ff && !rsp_tready) |=> out_full_ff) else $error("result dropped");
   a_speed_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT_MM && div_done) |=> rspd_ff != '0) else $error("zero ramp speed");
endmodule

FILE: rtl/core/stepper_ramp_pulse_generator.sv
// Stepper ramp pulse generator: one result transaction per request transaction.
// Stop, refused and idle commands and plain countdown ticks pass from S_IDLE through S_OUT
// into the response register; move, home, start and ticks that end a half period first
// run the 32-step iterative divider. The back end takes the next command once the response
// has left; a two-entry queue decouples input.
// Reset (synchronous, active high) clears motion state and loads register defaults.
module stepper_ramp_pulse_generator #(
   parameter int TicksPerSecond = srpg_pkg::TicksPerSecond
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // func[2:0], move_steps[27:3], move_speed[43:28], end_switch[44]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // step_out[0], dir_out[1], enable_out[2], position_now[26:3], steps_left[50:27],
   // speed_now[66:51], status[68:67]
   output logic [71:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   srpg_pkg::cmd_type cmd;
   logic cmd_pop;

   srpg_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .cmd, .cmd_pop
   );

   srpg_back #(.TicksPerSecond(TicksPerSecond)) u_back (
      .clock, .reset, .cmd, .cmd_pop, .csr_we, .csr_index, .csr_wdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );
endmodule

FILE: tb/stepper_ramp_pulse_generator_test.sv
// Self-checking testbench for the stepper ramp pulse generator.
// Depends on srpg_pkg and the stepper_ramp_pulse_generator RTL; it reads no files.
module stepper_ramp_pulse_generator_test;

   localparam int WatchdogLimit = 5000;
   localparam int HoldCycles    = 300;
   localparam logic [2:0] FUNC_UNUSED   = 3'd5;
   localparam logic [2:0] FUNC_RESERVED = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // func[2:0], move_steps[27:3], move_speed[43:28], end_switch[44]
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // step_out[0], dir_out[1], enable_out[2], position_now[26:3], steps_left[50:27],
   // speed_now[66:51], status[68:67]
   logic [71:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_wdata = '0;

   stepper_ramp_pulse_generator DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Register copy kept by the predictor.
   bit [15:0] cfg_accel, cfg_max_speed, cfg_min_speed, cfg_steps_per_mm;
   bit [23:0] cfg_max_position;
   bit        cfg_mm_mode, cfg_switch_present, cfg_enable_level;

   // Motion state kept by the predictor.
   bit [23:0] pos, left;
   bit [15:0] cur_speed, goal_speed;
   bit [18:0] half_count;
   bit        go_negative, homing, next_high, moving, pin;

   logic [47:0] cmd_pending[$];
   logic [71:0] motion_expected[$];
   int  error_count = 0;
   bit  calm = 1'b0;
   bit  hold_go = 1'b0;
   bit  hold_done = 1'b0;
   int  hold_count = 0;
   int  quiet_cycles = 0;

   function automatic int unsigned ramp_next(int unsigned spd, int unsigned togo);
      int unsigned acc;
      acc = (cfg_accel != 0) ? cfg_accel : 1;
      if (spd == 0) spd = cfg_min_speed;
      if (togo < spd / acc) spd = (spd > acc) ? spd - acc : 0;
      else if (spd < goal_speed) spd = spd + acc;
      if (spd < cfg_min_speed) spd = cfg_min_speed;
      if (spd > 65535) spd = 65535;
      return spd;
   endfunction

   function automatic bit [18:0] half_ticks();
      int unsigned d, h;
      d = (cur_speed != 0) ? cur_speed : 1;
      h = (srpg_pkg::TicksPerSecond / 2) / d;
      if (h == 0) h = 1;
      if (h > 19'h7FFFF) h = 19'h7FFFF;
      return h[18:0];
   endfunction

   function automatic bit blocked();
      return left == 0 || (pos == 0 && go_negative) ||
             (pos == cfg_max_position && !go_negative);
   endfunction

   function automatic void load_move(bit neg, int unsigned count, int unsigned spd);
      int unsigned div;
      div = (cfg_steps_per_mm != 0) ? cfg_steps_per_mm : 1;
      go_negative = neg;
      left = (count > 24'hFFFFFF) ? 24'hFFFFFF : count[23:0];
      if (cfg_mm_mode) spd = spd / div;
      goal_speed = (spd < cfg_max_speed) ? spd : cfg_max_speed;
      cur_speed = ramp_next(0, left);
   endfunction

   function automatic srpg_pkg::status_type run_tick(bit sw);
      if (!moving) return srpg_pkg::ST_IDLE;
      if (cfg_switch_present && go_negative) begin
         if (homing) begin
            pos = 1;
            left = cfg_max_position;
         end
         if (!sw) begin
            moving = 0;
            left = 0;
            pos = 0;
            homing = 0;
            return srpg_pkg::ST_SWITCH;
         end
      end
      if (blocked()) begin
         moving = 0;
         left = 0;
         return srpg_pkg::ST_IDLE;
      end
      if (half_count > 1) begin
         half_count--;
         return srpg_pkg::ST_RUN;
      end
      half_count = half_ticks();
      cur_speed = ramp_next(cur_speed, left);
      if (next_high) begin
         pin = 1;
         next_high = 0;
      end else begin
         pin = 0;
         next_high = 1;
         pos = go_negative ? pos - 1 : pos + 1;
         left = left - 1;
      end
      return srpg_pkg::ST_RUN;
   endfunction

   // Works out the response to one command transaction and updates the state.
   function automatic logic [71:0] predict_motion(logic [47:0] cmd);
      logic [2:0]  fn;
      logic [24:0] raw;
      logic [15:0] spd;
      srpg_pkg::status_type st;
      int unsigned mag;
      fn  = cmd[2:0];
      raw = cmd[27:3];
      spd = cmd[43:28];
      case (fn)
         srpg_pkg::FUNC_TICK: st = run_tick(cmd[44]);
         srpg_pkg::FUNC_MOVE: begin
            if (moving) st = srpg_pkg::ST_REFUSED;
            else begin
               mag = raw[24] ? ((32'h2000000 - raw) & 32'h1FFFFFF) : raw;
               load_move(raw[24], mag, spd);
               st = srpg_pkg::ST_RUN;
            end
         end
         srpg_pkg::FUNC_START: begin
            if (blocked()) st = srpg_pkg::ST_IDLE;
            else begin
               moving = 1;
               half_count = half_ticks();
               st = srpg_pkg::ST_RUN;
            end
         end
         srpg_pkg::FUNC_STOP: begin
            moving = 0;
            left = 0;
            st = srpg_pkg::ST_IDLE;
         end
         srpg_pkg::FUNC_HOME: begin
            if (moving) st = srpg_pkg::ST_REFUSED;
            else begin
               if (cfg_switch_present) pos = 1;
               load_move(pos != 0, pos, spd);
               if (cfg_switch_present) homing = 1;
               st = srpg_pkg::ST_RUN;
            end
         end
         default: st = srpg_pkg::ST_REFUSED;
      endcase
      return {3'b000, st, cur_speed, left, pos,
              moving ? cfg_enable_level : ~cfg_enable_level, go_negative, pin};
   endfunction

   task automatic report_mismatch(string field, logic [71:0] got, logic [71:0] want);
      $display("mismatch in %s: got %0h, expected %0h", field, got, want);
      error_count++;
   endtask

   // Driver: offers queued commands, holding each until it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            motion_expected.push_back(predict_motion(cmd_pending.pop_front()));
         end
         if (!(req_tvalid && !req_tready)) begin
            if (cmd_pending.size() > 0 && (calm || $urandom_range(99) >= 24)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= cmd_pending[0];
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off to fill the block.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_go && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_count <= hold_count + 1;
         if (hold_count == HoldCycles) hold_done <= 1'b1;
      end else begin
         rsp_tready <= calm || $urandom_range(99) >= 24;
      end
   end

   // Monitor: checks every response transaction field by field.
   always @(posedge clock) begin
      logic [71:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (motion_expected.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata, '0);
         end else begin
            want = motion_expected.pop_front();
            if (rsp_tdata[0] !== want[0]) report_mismatch("step_out", rsp_tdata[0], want[0]);
            if (rsp_tdata[1] !== want[1]) report_mismatch("dir_out", rsp_tdata[1], want[1]);
            if (rsp_tdata[2] !== want[2])
               report_mismatch("enable_out", rsp_tdata[2], want[2]);
            if (rsp_tdata[26:3] !== want[26:3])
               report_mismatch("position_now", rsp_tdata[26:3], want[26:3]);
            if (rsp_tdata[50:27] !== want[50:27])
               report_mismatch("steps_left", rsp_tdata[50:27], want[50:27]);
            if (rsp_tdata[66:51] !== want[66:51])
               report_mismatch("speed_now", rsp_tdata[66:51], want[66:51]);
            if (rsp_tdata[68:67] !== want[68:67])
               report_mismatch("status", rsp_tdata[68:67], want[68:67]);
         end
      end
   end

   // Watchdog on cycles with no transaction on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else if (!reset) quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic add_cmd(logic [2:0] fn, logic [24:0] steps, logic [15:0] spd, bit sw);
      cmd_pending.push_back({3'b000, sw, spd, steps, fn});
   endtask

   task automatic write_reg(logic [2:0] idx, logic [23:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         srpg_pkg::CSR_ACCEL:   cfg_accel = value[15:0];
         srpg_pkg::CSR_MAXSPD:  cfg_max_speed = value[15:0];
         srpg_pkg::CSR_MINSPD:  cfg_min_speed = value[15:0];
         srpg_pkg::CSR_MAXPOS:  cfg_max_position = value;
         srpg_pkg::CSR_SPMM:    cfg_steps_per_mm = value[15:0];
         srpg_pkg::CSR_MMMODE:  cfg_mm_mode = value[0];
         srpg_pkg::CSR_ENDSW:   cfg_switch_present = value[0];
         default:               cfg_enable_level = value[0];
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Waits until every command has been answered and the back end is quiet.
   task automatic drain();
      while (cmd_pending.size() > 0 || req_tvalid || motion_expected.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // Mostly well-formed move or home, start and tick runs, some ending in a stop; the rest is random noise.
   task automatic random_traffic(int budget, int max_steps);
      int n, k;
      logic [24:0] steps;
      while (budget > 0) begin
         if ($urandom_range(99) < 70) begin
            steps = 25'($urandom_range(max_steps, 1));
            if ($urandom_range(1)) steps = -steps;
            if ($urandom_range(5) == 0)
               add_cmd(srpg_pkg::FUNC_HOME, 25'($urandom), 16'($urandom), 1'b1);
            else add_cmd(srpg_pkg::FUNC_MOVE, steps, 16'($urandom), 1'b1);
            add_cmd(srpg_pkg::FUNC_START, 25'($urandom), 16'($urandom), 1'($urandom));
            n = $urandom_range(40, 10);
            for (k = 0; k < n; k++) add_cmd(srpg_pkg::FUNC_TICK, 25'($urandom),
                                             16'($urandom), $urandom_range(19) != 0);
            if ($urandom_range(3) == 0)
               add_cmd(srpg_pkg::FUNC_STOP, 25'($urandom), 16'($urandom), 1'($urandom));
            budget -= n + 2;
         end else begin
            add_cmd(3'($urandom_range(7)), 25'($urandom), 16'($urandom), 1'($urandom));
            budget--;
         end
      end
   endtask

   initial begin
      cfg_accel = 10;  cfg_max_speed = 2000; cfg_min_speed = 10;
      cfg_max_position = 24'hFFFFFF; cfg_steps_per_mm = 1;
      cfg_mm_mode = 0; cfg_switch_present = 0; cfg_enable_level = 0;
      {pos, left, cur_speed, goal_speed, half_count} = '0;
      {go_negative, homing, next_high, moving, pin} = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed checks at reset defaults: idle commands, unused codes, extremes.
      add_cmd(srpg_pkg::FUNC_TICK, '0, '0, 1'b0);
      add_cmd(srpg_pkg::FUNC_STOP, '0, '0, 1'b1);
      add_cmd(FUNC_UNUSED, '1, '1, 1'b1);
      add_cmd(FUNC_RESERVED, '0, '0, 1'b0);
      add_cmd(srpg_pkg::FUNC_START, '0, '0, 1'b1);
      add_cmd(srpg_pkg::FUNC_MOVE, 25'h1000000, 16'd0, 1'b1);
      add_cmd(srpg_pkg::FUNC_MOVE, 25'h0FFFFFF, 16'hFFFF, 1'b1);
      add_cmd(srpg_pkg::FUNC_START, '0, '0, 1'b1);
      add_cmd(srpg_pkg::FUNC_MOVE, 25'd5, 16'd100, 1'b1);
      add_cmd(srpg_pkg::FUNC_HOME, '0, 16'd100, 1'b1);
      add_cmd(srpg_pkg::FUNC_START, '0, '0, 1'b1);
      add_cmd(srpg_pkg::FUNC_TICK, '0, '0, 1'b1);
      add_cmd(srpg_pkg::FUNC_STOP, '0, '0, 1'b0);
      add_cmd(srpg_pkg::FUNC_MOVE, -25'sd3, 16'd500, 1'b1);
      add_cmd(srpg_pkg::FUNC_START, '0, '0, 1'b1);
      add_cmd(srpg_pkg::FUNC_TICK, '0, '0, 1'b1);
      drain();

      // Fast ramp, short travel range; long receiver hold-off while sending.
      write_reg(srpg_pkg::CSR_MINSPD, 24'd50000);
      write_reg(srpg_pkg::CSR_ACCEL, 24'd1);
      write_reg(srpg_pkg::CSR_MAXSPD, 24'hFFFF);
      write_reg(srpg_pkg::CSR_MAXPOS, 24'd20);
      write_reg(srpg_pkg::CSR_ENLEVEL, 24'd1);
      end_writes();
      hold_go = 1'b1;
      random_traffic(130, 6);
      drain();

      // Homing with an end switch, mm mode, extreme ramp settings, no idling.
      calm = 1'b1;
      write_reg(srpg_pkg::CSR_ENDSW, 24'd1);
      write_reg(srpg_pkg::CSR_MMMODE, 24'd1);
      write_reg(srpg_pkg::CSR_SPMM, 24'd3);
      write_reg(srpg_pkg::CSR_ACCEL, 24'hFFFF);
      write_reg(srpg_pkg::CSR_MINSPD, 24'hFFFF);
      write_reg(srpg_pkg::CSR_MAXPOS, 24'hFFFFFF);
      end_writes();
      add_cmd(srpg_pkg::FUNC_MOVE, 25'd4, 16'hFFFF, 1'b1);
      add_cmd(srpg_pkg::FUNC_START, '0, '0, 1'b1);
      repeat (20) add_cmd(srpg_pkg::FUNC_TICK, '0, '0, 1'b1);
      add_cmd(srpg_pkg::FUNC_HOME, '0, 16'hFFFF, 1'b1);
      add_cmd(srpg_pkg::FUNC_START, '0, '0, 1'b1);
      repeat (5) add_cmd(srpg_pkg::FUNC_TICK, '0, '0, 1'b1);
      add_cmd(srpg_pkg::FUNC_TICK, '0, '0, 1'b0);
      random_traffic(100, 4);
      drain();
      calm = 1'b0;

      // Slowest ramp floor, zero travel range, then back toward defaults.
      write_reg(srpg_pkg::CSR_MINSPD, 24'd1);
      write_reg(srpg_pkg::CSR_MAXPOS, 24'd0);
      write_reg(srpg_pkg::CSR_SPMM, 24'hFFFF);
      write_reg(srpg_pkg::CSR_MAXSPD, 24'd1);
      end_writes();
      random_traffic(40, 3);
      drain();
      write_reg(srpg_pkg::CSR_MINSPD, 24'd40000);
      write_reg(srpg_pkg::CSR_MAXPOS, 24'd100);
      write_reg(srpg_pkg::CSR_MAXSPD, 24'd2000);
      write_reg(srpg_pkg::CSR_ACCEL, 24'd10);
      write_reg(srpg_pkg::CSR_SPMM, 24'd1);
      write_reg(srpg_pkg::CSR_MMMODE, 24'd0);
      write_reg(srpg_pkg::CSR_ENDSW, 24'd0);
      write_reg(srpg_pkg::CSR_ENLEVEL, 24'd0);
      end_writes();
      random_traffic(120, 8);
      drain();

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
